// File: hw/rtl/sjfs_pkg.sv
// Shared types, widths and saturating time helpers for the SJF scheduler.
package sjfs_pkg;

    // Default capacity of the job chain.
    localparam int MAX_JOBS_DEF = 16;

    // Fixed field widths of the job and result words.
    localparam int ARR_W     = 16;
    localparam int BURST_W   = 16;
    localparam int TIME_W    = 21;
    localparam int OUT_IDX_W = 4;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Controller states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    // Control from the sequencer to the selection unit.
    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

    // Time plus burst, held at the top of the time range.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [BURST_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {{(TIME_W + 1 - BURST_W){1'b0}}, b};
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    // Difference that stops at zero instead of wrapping.
    function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

// File: hw/rtl/sjfs_cell.sv
// One job cell of the scheduler chain: holds a job and passes it to its neighbor.
module sjfs_cell #(
    parameter int IDX_W = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic                        i_clear,
    input  logic                        i_valid,
    input  logic                        i_done,
    input  logic [sjfs_pkg::ARR_W-1:0]   i_arr,
    input  logic [sjfs_pkg::BURST_W-1:0] i_burst,
    input  logic [IDX_W-1:0]            i_idx,
    output logic                        o_valid,
    output logic                        o_done,
    output logic [sjfs_pkg::ARR_W-1:0]   o_arr,
    output logic [sjfs_pkg::BURST_W-1:0] o_burst,
    output logic [IDX_W-1:0]            o_idx
);

    logic                        r_valid;
    logic                        r_done;
    logic [sjfs_pkg::ARR_W-1:0]   r_arr;
    logic [sjfs_pkg::BURST_W-1:0] r_burst;
    logic [IDX_W-1:0]            r_idx;

    // Occupancy and completion flags are cleared by reset and at the end of a run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
            r_done  <= i_done;
        end
    end

    // Job payload moves with the chain and needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_arr   <= i_arr;
            r_burst <= i_burst;
            r_idx   <= i_idx;
        end
    end

    assign o_valid = r_valid;
    assign o_done  = r_done;
    assign o_arr   = r_arr;
    assign o_burst = r_burst;
    assign o_idx   = r_idx;

endmodule

// File: hw/rtl/sjfs_sel.sv
// Selection unit: watches the job at the head of the chain during one full pass.
module sjfs_sel #(
    parameter int IDX_W = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sjfs_pkg::t_scan_ctl          i_ctl,
    input  logic [sjfs_pkg::TIME_W-1:0]  i_now,
    input  logic                        i_valid,
    input  logic                        i_done,
    input  logic [sjfs_pkg::ARR_W-1:0]   i_arr,
    input  logic [sjfs_pkg::BURST_W-1:0] i_burst,
    input  logic [IDX_W-1:0]            i_idx,
    output logic                        o_found,
    output logic [IDX_W-1:0]            o_best_idx,
    output logic [sjfs_pkg::ARR_W-1:0]   o_best_arr,
    output logic [sjfs_pkg::BURST_W-1:0] o_best_burst,
    output logic                        o_any,
    output logic [sjfs_pkg::ARR_W-1:0]   o_min_arr
);

    logic                        r_found;
    logic [IDX_W-1:0]            r_best_idx;
    logic [sjfs_pkg::ARR_W-1:0]   r_best_arr;
    logic [sjfs_pkg::BURST_W-1:0] r_best_burst;
    logic                        r_any;
    logic [sjfs_pkg::ARR_W-1:0]   r_min_arr;

    logic pending;
    logic eligible;
    logic better;
    logic earlier;

    // A pending job is eligible once it has arrived; shorter burst wins, then lower index.
    always_comb begin
        pending  = i_valid && !i_done;
        eligible = pending &&
                   ({{(sjfs_pkg::TIME_W - sjfs_pkg::ARR_W){1'b0}}, i_arr} <= i_now);
        better   = !r_found || (i_burst < r_best_burst) ||
                   ((i_burst == r_best_burst) && (i_idx < r_best_idx));
        earlier  = !r_any || (i_arr < r_min_arr);
    end

    // Flags of the running pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_found <= 1'b0;
            r_any   <= 1'b0;
        end else if (i_ctl.step) begin
            if (eligible && better) begin
                r_found <= 1'b1;
            end
            if (pending && earlier) begin
                r_any <= 1'b1;
            end
        end
    end

    // Best candidate and earliest pending arrival seen so far.
    always_ff @(posedge i_clk) begin
        if (i_ctl.step && !i_ctl.clear) begin
            if (eligible && better) begin
                r_best_idx   <= i_idx;
                r_best_arr   <= i_arr;
                r_best_burst <= i_burst;
            end
            if (pending && earlier) begin
                r_min_arr <= i_arr;
            end
        end
    end

    assign o_found      = r_found;
    assign o_best_idx   = r_best_idx;
    assign o_best_arr   = r_best_arr;
    assign o_best_burst = r_best_burst;
    assign o_any        = r_any;
    assign o_min_arr    = r_min_arr;

endmodule

// File: hw/rtl/sjf_nonpreemptive_scheduler.sv
// Top level of the non-preemptive shortest-job-first scheduler.
//
// Usage: jobs enter one word at a time on the input channel (i_in_valid /
// o_in_ready) with an arrival time and a burst length; i_last_job marks the
// final job of a set. Jobs are kept in a chain of MAX_JOBS cells in load
// order; jobs beyond MAX_JOBS are dropped. After the last job the block
// schedules the set from time zero and returns one result word per job on
// the output channel (o_out_valid / i_out_ready), in execution order, with
// o_last_result on the final one. The input channel is closed from the last
// job until the final result has been placed in the output register.
// Each decision rotates the whole chain once past the selection unit; when no
// job has arrived yet, time jumps to the earliest pending arrival and one
// more pass follows.
// Reset empties the chain and the output register. A stalled receiver holds
// the output word; the block finishes the next decision and then waits.
module sjf_nonpreemptive_scheduler #(
    parameter int MAX_JOBS = sjfs_pkg::MAX_JOBS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sjfs_pkg::ARR_W-1:0]     i_arrival_time,
    input  logic [sjfs_pkg::BURST_W-1:0]   i_burst_time,
    input  logic                          i_last_job,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sjfs_pkg::OUT_IDX_W-1:0] o_job_index,
    output logic [sjfs_pkg::TIME_W-1:0]    o_start_time,
    output logic [sjfs_pkg::TIME_W-1:0]    o_completion_time,
    output logic [sjfs_pkg::TIME_W-1:0]    o_turnaround_time,
    output logic [sjfs_pkg::TIME_W-1:0]    o_waiting_time,
    output logic                          o_last_result
);

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int TW    = sjfs_pkg::TIME_W;

    sjfs_pkg::t_state r_state;
    sjfs_pkg::t_state n_state;

    logic [CNT_W-1:0] r_loaded;
    logic [CNT_W-1:0] r_emitted;
    logic [IDX_W-1:0] r_scan_cnt;
    logic [TW-1:0]    r_now;
    logic [TW-1:0]    r_fin;
    logic             r_mark_vld;
    logic [IDX_W-1:0] r_mark_idx;

    logic                            r_out_valid;
    logic [sjfs_pkg::OUT_IDX_W-1:0]  r_job_index;
    logic [TW-1:0]                   r_start;
    logic [TW-1:0]                   r_compl;
    logic [TW-1:0]                   r_tat;
    logic [TW-1:0]                   r_wait;
    logic                            r_last;

    // Chain taps.
    logic                        c_valid [MAX_JOBS];
    logic                        c_done  [MAX_JOBS];
    logic [sjfs_pkg::ARR_W-1:0]   c_arr   [MAX_JOBS];
    logic [sjfs_pkg::BURST_W-1:0] c_burst [MAX_JOBS];
    logic [IDX_W-1:0]            c_idx   [MAX_JOBS];

    logic                        in_valid;
    logic                        in_done;
    logic [sjfs_pkg::ARR_W-1:0]   in_arr;
    logic [sjfs_pkg::BURST_W-1:0] in_burst;
    logic [IDX_W-1:0]            in_idx;

    logic                        head_done;
    logic                        sel_found;
    logic [IDX_W-1:0]            sel_idx;
    logic [sjfs_pkg::ARR_W-1:0]   sel_arr;
    logic [sjfs_pkg::BURST_W-1:0] sel_burst;
    logic                        sel_any;
    logic [sjfs_pkg::ARR_W-1:0]   sel_min_arr;

    sjfs_pkg::t_scan_ctl sel_ctl;

    logic in_fire;
    logic full;
    logic load_fire;
    logic sched_start;
    logic scan_last;
    logic out_free;
    logic emit_fire;
    logic last_emit;
    logic run_end;
    logic chain_shift;
    logic [CNT_W-1:0] emitted_inc;
    logic [TW-1:0]    tat_val;

    // Handshake and sequencing conditions.
    always_comb begin
        in_fire     = i_in_valid && o_in_ready;
        full        = (r_loaded == CNT_W'(MAX_JOBS));
        load_fire   = in_fire && !full;
        sched_start = in_fire && i_last_job;
        scan_last   = (r_scan_cnt == IDX_W'(MAX_JOBS - 1));
        out_free    = !r_out_valid || i_out_ready;
        emitted_inc = r_emitted + CNT_W'(1);
        last_emit   = (emitted_inc == r_loaded);
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sjfs_pkg::ST_LOAD: begin
                if (sched_start) begin
                    n_state = sjfs_pkg::ST_SCAN;
                end
            end
            sjfs_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = sjfs_pkg::ST_DECIDE;
                end
            end
            sjfs_pkg::ST_DECIDE: begin
                if (sel_found) begin
                    n_state = sjfs_pkg::ST_EMIT;
                end else if (sel_any) begin
                    n_state = sjfs_pkg::ST_SCAN;
                end else begin
                    n_state = sjfs_pkg::ST_LOAD;
                end
            end
            sjfs_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = last_emit ? sjfs_pkg::ST_LOAD : sjfs_pkg::ST_SCAN;
                end
            end
            default: begin
                n_state = sjfs_pkg::ST_LOAD;
            end
        endcase
    end

    // State-dependent controls.
    always_comb begin
        o_in_ready    = 1'b0;
        chain_shift   = 1'b0;
        sel_ctl.clear = 1'b0;
        sel_ctl.step  = 1'b0;
        emit_fire     = 1'b0;
        run_end       = 1'b0;
        case (r_state)
            sjfs_pkg::ST_LOAD: begin
                o_in_ready    = 1'b1;
                chain_shift   = load_fire;
                sel_ctl.clear = 1'b1;
            end
            sjfs_pkg::ST_SCAN: begin
                chain_shift  = 1'b1;
                sel_ctl.step = 1'b1;
            end
            sjfs_pkg::ST_DECIDE: begin
                run_end = !sel_found && !sel_any;
            end
            sjfs_pkg::ST_EMIT: begin
                sel_ctl.clear = 1'b1;
                emit_fire     = out_free;
                run_end       = out_free && last_emit;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // The head job gets its done flag when it is the job just scheduled.
    assign head_done = c_done[MAX_JOBS-1] ||
                       (r_mark_vld && (c_idx[MAX_JOBS-1] == r_mark_idx));

    // Cell zero takes a new job while loading and the head job while rotating.
    always_comb begin
        if (r_state == sjfs_pkg::ST_LOAD) begin
            in_valid = 1'b1;
            in_done  = 1'b0;
            in_arr   = i_arrival_time;
            in_burst = i_burst_time;
            in_idx   = r_loaded[IDX_W-1:0];
        end else begin
            in_valid = c_valid[MAX_JOBS-1];
            in_done  = head_done;
            in_arr   = c_arr[MAX_JOBS-1];
            in_burst = c_burst[MAX_JOBS-1];
            in_idx   = c_idx[MAX_JOBS-1];
        end
    end

    // The chain of job cells.
    for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
        if (g == 0) begin : g_first
            sjfs_cell #(.IDX_W(IDX_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (chain_shift),
                .i_clear (run_end),
                .i_valid (in_valid),
                .i_done  (in_done),
                .i_arr   (in_arr),
                .i_burst (in_burst),
                .i_idx   (in_idx),
                .o_valid (c_valid[g]),
                .o_done  (c_done[g]),
                .o_arr   (c_arr[g]),
                .o_burst (c_burst[g]),
                .o_idx   (c_idx[g])
            );
        end else begin : g_rest
            sjfs_cell #(.IDX_W(IDX_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (chain_shift),
                .i_clear (run_end),
                .i_valid (c_valid[g-1]),
                .i_done  (c_done[g-1]),
                .i_arr   (c_arr[g-1]),
                .i_burst (c_burst[g-1]),
                .i_idx   (c_idx[g-1]),
                .o_valid (c_valid[g]),
                .o_done  (c_done[g]),
                .o_arr   (c_arr[g]),
                .o_burst (c_burst[g]),
                .o_idx   (c_idx[g])
            );
        end
    end

    // Selection over one pass of the chain.
    sjfs_sel #(.IDX_W(IDX_W)) u_sel (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (sel_ctl),
        .i_now        (r_now),
        .i_valid      (c_valid[MAX_JOBS-1]),
        .i_done       (head_done),
        .i_arr        (c_arr[MAX_JOBS-1]),
        .i_burst      (c_burst[MAX_JOBS-1]),
        .i_idx        (c_idx[MAX_JOBS-1]),
        .o_found      (sel_found),
        .o_best_idx   (sel_idx),
        .o_best_arr   (sel_arr),
        .o_best_burst (sel_burst),
        .o_any        (sel_any),
        .o_min_arr    (sel_min_arr)
    );

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sjfs_pkg::ST_LOAD;
            r_loaded   <= '0;
            r_emitted  <= '0;
            r_scan_cnt <= '0;
            r_now      <= '0;
            r_mark_vld <= 1'b0;
        end else begin
            r_state <= n_state;

            if (run_end) begin
                r_loaded <= '0;
            end else if (load_fire) begin
                r_loaded <= r_loaded + CNT_W'(1);
            end

            if (sched_start) begin
                r_emitted <= '0;
            end else if (emit_fire) begin
                r_emitted <= emitted_inc;
            end

            if (r_state == sjfs_pkg::ST_SCAN && !scan_last) begin
                r_scan_cnt <= r_scan_cnt + IDX_W'(1);
            end else begin
                r_scan_cnt <= '0;
            end

            if (sched_start || run_end) begin
                r_now <= '0;
            end else if (r_state == sjfs_pkg::ST_DECIDE && !sel_found && sel_any) begin
                r_now <= {{(TW - sjfs_pkg::ARR_W){1'b0}}, sel_min_arr};
            end else if (emit_fire) begin
                r_now <= r_fin;
            end

            if (run_end) begin
                r_mark_vld <= 1'b0;
            end else if (r_state == sjfs_pkg::ST_DECIDE && sel_found) begin
                r_mark_vld <= 1'b1;
            end
        end
    end

    // Chosen job and its completion time.
    always_ff @(posedge i_clk) begin
        if (r_state == sjfs_pkg::ST_DECIDE && sel_found) begin
            r_mark_idx <= sel_idx;
            r_fin      <= sjfs_pkg::sat_add(r_now, sel_burst);
        end
    end

    assign tat_val = sjfs_pkg::sat_sub(r_fin, {{(TW - sjfs_pkg::ARR_W){1'b0}}, sel_arr});

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_job_index <= sjfs_pkg::OUT_IDX_W'(sel_idx);
            r_start     <= r_now;
            r_compl     <= r_fin;
            r_tat       <= tat_val;
            r_wait      <= sjfs_pkg::sat_sub(tat_val,
                               {{(TW - sjfs_pkg::BURST_W){1'b0}}, sel_burst});
            r_last      <= last_emit;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_job_index       = r_job_index;
    assign o_start_time      = r_start;
    assign o_completion_time = r_compl;
    assign o_turnaround_time = r_tat;
    assign o_waiting_time    = r_wait;
    assign o_last_result     = r_last;

endmodule

// File: hw/rtl/sjfs_checker.sv
// Port-level checks for the SJF scheduler, bound to its top level.
module sjfs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_last_job,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [sjfs_pkg::OUT_IDX_W-1:0] o_job_index,
    input logic [sjfs_pkg::TIME_W-1:0]    o_completion_time,
    input logic                          o_last_result
);

    // Reset leaves the block open for jobs with nothing to deliver.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("block not idle after reset");

    // A stalled result word keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_job_index) && $stable(o_completion_time)))
        else $error("stalled result word changed");

    // The last job of a set closes the input channel for scheduling.
    a_close_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last_job) |=> !o_in_ready)
        else $error("input open right after the last job");

    // While a schedule is still being delivered no new job is taken.
    a_no_load_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_result) |-> !o_in_ready)
        else $error("input open during a schedule");

endmodule

bind sjf_nonpreemptive_scheduler sjfs_checker u_sjfs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .i_last_job        (i_last_job),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_job_index       (o_job_index),
    .o_completion_time (o_completion_time),
    .o_last_result     (o_last_result)
);

// File: dv/tb_sjf_nonpreemptive_scheduler.sv
// Self-checking testbench for the non-preemptive shortest-job-first scheduler.
`timescale 1ns / 1ps

module tb_sjf_nonpreemptive_scheduler;

    localparam int JOBS         = sjfs_pkg::MAX_JOBS_DEF;
    localparam int ITEM_TARGET  = 460;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int STALL_LIMIT  = 4000;

    // One scheduled job as it leaves the block.
    typedef struct packed {
        logic [sjfs_pkg::OUT_IDX_W-1:0] job_idx;
        logic [sjfs_pkg::TIME_W-1:0]    start_t;
        logic [sjfs_pkg::TIME_W-1:0]    finish_t;
        logic [sjfs_pkg::TIME_W-1:0]    turnaround;
        logic [sjfs_pkg::TIME_W-1:0]    waiting;
        logic                           last;
    } t_sched_word;

    // One row of the directed table; typed rows carry their known result.
    typedef struct packed {
        logic [sjfs_pkg::ARR_W-1:0]   arr;
        logic [sjfs_pkg::BURST_W-1:0] burst;
        logic                         last;
        logic                         typed;
        t_sched_word                  word;
    } t_stim_row;

    localparam t_sched_word NO_WORD = '0;

    localparam t_stim_row DIR_ROWS [25] = '{
        // Single-job sets whose result is plain: extremes of arrival and burst.
        '{16'd0,     16'd0,     1'b1, 1'b1, '{4'd0, 21'd0, 21'd0, 21'd0, 21'd0, 1'b1}},
        '{16'd65535, 16'd65535, 1'b1, 1'b1,
          '{4'd0, 21'd65535, 21'd131070, 21'd65535, 21'd0, 1'b1}},
        '{16'd0,     16'd65535, 1'b1, 1'b1,
          '{4'd0, 21'd0, 21'd65535, 21'd65535, 21'd0, 1'b1}},
        '{16'd65535, 16'd0,     1'b1, 1'b1,
          '{4'd0, 21'd65535, 21'd65535, 21'd0, 21'd0, 1'b1}},
        // Tie on burst at time zero, then idle gaps before later arrivals.
        '{16'd10, 16'd5, 1'b0, 1'b0, NO_WORD},
        '{16'd0,  16'd3, 1'b0, 1'b0, NO_WORD},
        '{16'd0,  16'd3, 1'b0, 1'b0, NO_WORD},
        '{16'd40, 16'd2, 1'b1, 1'b0, NO_WORD},
        // Full store with ties and zero bursts; the seventeenth job is dropped.
        '{16'd0,  16'd9,     1'b0, 1'b0, NO_WORD},
        '{16'd0,  16'd4,     1'b0, 1'b0, NO_WORD},
        '{16'd3,  16'd4,     1'b0, 1'b0, NO_WORD},
        '{16'd0,  16'd65535, 1'b0, 1'b0, NO_WORD},
        '{16'd20, 16'd0,     1'b0, 1'b0, NO_WORD},
        '{16'd0,  16'd7,     1'b0, 1'b0, NO_WORD},
        '{16'd1,  16'd2,     1'b0, 1'b0, NO_WORD},
        '{16'd5,  16'd2,     1'b0, 1'b0, NO_WORD},
        '{16'd0,  16'd300,   1'b0, 1'b0, NO_WORD},
        '{16'd2,  16'd1,     1'b0, 1'b0, NO_WORD},
        '{16'd0,  16'd12,    1'b0, 1'b0, NO_WORD},
        '{16'd0,  16'd4,     1'b0, 1'b0, NO_WORD},
        '{16'd40, 16'd0,     1'b0, 1'b0, NO_WORD},
        '{16'd0,  16'd50,    1'b0, 1'b0, NO_WORD},
        '{16'd8,  16'd3,     1'b0, 1'b0, NO_WORD},
        '{16'd0,  16'd6,     1'b0, 1'b0, NO_WORD},
        '{16'd5,  16'd1,     1'b1, 1'b0, NO_WORD}
    };

    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           i_in_valid     = 1'b0;
    logic [sjfs_pkg::ARR_W-1:0]     i_arrival_time = '0;
    logic [sjfs_pkg::BURST_W-1:0]   i_burst_time   = '0;
    logic                           i_last_job     = 1'b0;
    logic                           i_out_ready    = 1'b0;
    logic                           o_in_ready;
    logic                           o_out_valid;
    logic [sjfs_pkg::OUT_IDX_W-1:0] o_job_index;
    logic [sjfs_pkg::TIME_W-1:0]    o_start_time;
    logic [sjfs_pkg::TIME_W-1:0]    o_completion_time;
    logic [sjfs_pkg::TIME_W-1:0]    o_turnaround_time;
    logic [sjfs_pkg::TIME_W-1:0]    o_waiting_time;
    logic                           o_last_result;

    // Predictor state: the jobs of the set being loaded.
    logic [sjfs_pkg::ARR_W-1:0]   held_arr   [JOBS];
    logic [sjfs_pkg::BURST_W-1:0] held_burst [JOBS];
    int                           held_count = 0;

    t_sched_word sched_q [$];
    t_sched_word want;
    int          fail_count  = 0;
    int          jobs_sent   = 0;
    int          quiet_count = 0;
    bit          rx_hold_go   = 1'b0;
    bit          rx_hold_done = 1'b0;

    sjf_nonpreemptive_scheduler dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_arrival_time    (i_arrival_time),
        .i_burst_time      (i_burst_time),
        .i_last_job        (i_last_job),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_job_index       (o_job_index),
        .o_start_time      (o_start_time),
        .o_completion_time (o_completion_time),
        .o_turnaround_time (o_turnaround_time),
        .o_waiting_time    (o_waiting_time),
        .o_last_result     (o_last_result)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Schedule the held set from time zero and queue one result per job.
    function automatic void run_schedule();
        bit [JOBS-1:0] finished;
        int unsigned   now_t;
        int unsigned   fin_t;
        int unsigned   next_t;
        int unsigned   best_burst;
        int unsigned   tat;
        int            pick;
        int            emitted;
        bit            found;
        t_sched_word   w;
        finished = '0;
        now_t    = 0;
        emitted  = 0;
        while (emitted < held_count) begin
            found      = 1'b0;
            pick       = 0;
            best_burst = 0;
            for (int i = 0; i < held_count; i++) begin
                if (!finished[i] && held_arr[i] <= now_t &&
                    (!found || held_burst[i] < best_burst)) begin
                    found      = 1'b1;
                    best_burst = held_burst[i];
                    pick       = i;
                end
            end
            if (!found) begin
                // Nothing has arrived yet, so time skips to the earliest pending arrival.
                next_t = 32'hFFFF_FFFF;
                for (int i = 0; i < held_count; i++) begin
                    if (!finished[i] && held_arr[i] < next_t) begin
                        next_t = held_arr[i];
                    end
                end
                now_t = next_t;
            end else begin
                fin_t = now_t + best_burst;
                if (fin_t > sjfs_pkg::TIME_MAX) begin
                    fin_t = sjfs_pkg::TIME_MAX;
                end
                tat = (fin_t > held_arr[pick]) ? fin_t - held_arr[pick] : 0;
                w.job_idx    = sjfs_pkg::OUT_IDX_W'(pick);
                w.start_t    = sjfs_pkg::TIME_W'(now_t);
                w.finish_t   = sjfs_pkg::TIME_W'(fin_t);
                w.turnaround = sjfs_pkg::TIME_W'(tat);
                w.waiting    = sjfs_pkg::TIME_W'((tat > best_burst) ? tat - best_burst : 0);
                finished[pick] = 1'b1;
                emitted++;
                w.last = (emitted == held_count);
                sched_q.push_back(w);
                now_t = fin_t;
            end
        end
    endfunction

    // Take one accepted job into the predictor; a full store drops it.
    task automatic load_job(input logic [sjfs_pkg::ARR_W-1:0]   arr,
                            input logic [sjfs_pkg::BURST_W-1:0] burst,
                            input logic                         last);
        if (held_count < JOBS) begin
            held_arr[held_count]   = arr;
            held_burst[held_count] = burst;
            held_count++;
        end
        if (last) begin
            run_schedule();
            held_count = 0;
        end
    endtask

    // Mostly no gap, sometimes a short one, rarely a long pause.
    function automatic int gap_len(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Offer one job word after a gap and wait until the block takes it.
    task automatic offer_job(input logic [sjfs_pkg::ARR_W-1:0]   arr,
                             input logic [sjfs_pkg::BURST_W-1:0] burst,
                             input logic                         last,
                             input int                           gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_arrival_time <= arr;
        i_burst_time   <= burst;
        i_last_job     <= last;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        load_job(arr, burst, last);
        jobs_sent++;
    endtask

    task automatic check_field(input string name,
                               input logic [sjfs_pkg::TIME_W-1:0] exp_val,
                               input logic [sjfs_pkg::TIME_W-1:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
            fail_count++;
        end
    endtask

    // Sender: reset, directed table, random job sets, then drain and report.
    initial begin : job_source
        int          r;
        int          set_len;
        bit          steady;
        logic [15:0] arr_mask;
        logic [15:0] burst_mask;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[k]) begin
            offer_job(DIR_ROWS[k].arr, DIR_ROWS[k].burst, DIR_ROWS[k].last, gap_len(1'b0));
            if (DIR_ROWS[k].typed) begin
                // Single-job rows carry their result; it takes the computed one's place.
                void'(sched_q.pop_back());
                sched_q.push_back(DIR_ROWS[k].word);
            end
        end

        // The receiver stalls for a long stretch at the start of the random part.
        rx_hold_go = 1'b1;
        while (jobs_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                set_len = $urandom_range(JOBS + 1, JOBS + 4);
            end else if (r < 30) begin
                set_len = JOBS;
            end else begin
                set_len = $urandom_range(1, JOBS - 1);
            end
            case ($urandom_range(0, 3))
                0:       arr_mask = 16'h000F;
                1:       arr_mask = 16'h00FF;
                2:       arr_mask = 16'h0FFF;
                default: arr_mask = 16'hFFFF;
            endcase
            case ($urandom_range(0, 2))
                0:       burst_mask = 16'h0007;
                1:       burst_mask = 16'h00FF;
                default: burst_mask = 16'hFFFF;
            endcase
            steady = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < set_len; j++) begin
                offer_job(16'($urandom()) & arr_mask, 16'($urandom()) & burst_mask,
                          j == set_len - 1, gap_len(steady));
            end
        end
        i_in_valid <= 1'b0;

        while (sched_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS sjf_nonpreemptive_scheduler");
        end else begin
            $display("FAIL sjf_nonpreemptive_scheduler");
        end
        $finish;
    end

    // Receiver: random ready gaps, steady stretches, and one long hold.
    initial begin : result_sink
        int gap;
        int steady_left;
        steady_left = 0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_go && !rx_hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_done = 1'b1;
            end else begin
                if (steady_left > 0) begin
                    steady_left--;
                end else if ($urandom_range(0, 7) == 0) begin
                    steady_left = $urandom_range(20, 60);
                end
                gap = gap_len(steady_left > 0);
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1 && !(rx_hold_go && !rx_hold_done)) @(posedge i_clk);
        end
    end

    // Compare each accepted result word with the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (sched_q.size() == 0) begin
                $display("%0t: result word with none expected, job_index %0d",
                         $time, o_job_index);
                fail_count++;
            end else begin
                want = sched_q.pop_front();
                check_field("job_index", sjfs_pkg::TIME_W'(want.job_idx),
                            sjfs_pkg::TIME_W'(o_job_index));
                check_field("start_time", want.start_t, o_start_time);
                check_field("completion_time", want.finish_t, o_completion_time);
                check_field("turnaround_time", want.turnaround, o_turnaround_time);
                check_field("waiting_time", want.waiting, o_waiting_time);
                check_field("last_result", sjfs_pkg::TIME_W'(want.last),
                            sjfs_pkg::TIME_W'(o_last_result));
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)) begin
            quiet_count <= 0;
        end else if (quiet_count + 1 >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL sjf_nonpreemptive_scheduler");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

endmodule
